[src/lmcp_pkg.sv]
// shared types and constants of the led matrix channel to pixel mapper
package lmcp_pkg;

    // widths of the configuration registers and position counters
    localparam int unsigned SIZE_W   = 10;
    localparam int unsigned SKIP_W   = 24;
    localparam int unsigned LAYOUT_W = 3;
    localparam int unsigned COORD_W  = 9;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 24;

    // pixel queue between the front and back parts
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW    = 2;
    localparam int unsigned QUEUE_CW    = 3;

    // output word: x, y, red, green, blue, padded to whole bytes
    localparam int unsigned OUT_DATA_W = 48;
    localparam int unsigned OUT_PAD_W  = OUT_DATA_W - 2 * COORD_W - 24;

    // channels per pixel and channel phase codes
    localparam logic [2:0] CH_RGB       = 3'd3;
    localparam logic [2:0] CH_RGBW      = 3'd4;
    localparam logic [2:0] CH_HAS_GREEN = 3'd2;
    localparam logic [1:0] PHASE_WHITE  = 2'd3;

    // layout bits
    localparam int unsigned LAYOUT_RIGHT  = 0;
    localparam int unsigned LAYOUT_BOTTOM = 1;
    localparam int unsigned LAYOUT_VERT   = 2;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SERPENTINE = 3'd0,
        REG_RGBW       = 3'd1,
        REG_WIDTH      = 3'd2,
        REG_HEIGHT     = 3'd3,
        REG_START      = 3'd4,
        REG_STRANDS    = 3'd5,
        REG_LAYOUT     = 3'd6
    } t_cfg_reg;

    typedef struct packed {
        logic                serpentine_mode;
        logic                rgbw_enable;
        logic [SIZE_W-1:0]   width;
        logic [SIZE_W-1:0]   height;
        logic [SKIP_W-1:0]   start_offset;
        logic [SIZE_W-1:0]   strands_per_string;
        logic [LAYOUT_W-1:0] layout;
    } t_cfg;

    typedef struct packed {
        logic [COORD_W-1:0] pixel_x;
        logic [COORD_W-1:0] pixel_y;
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
        logic               last_pixel;
    } t_pixel;

    typedef struct packed {
        logic                empty;
        logic                full;
        logic [QUEUE_CW-1:0] count;
    } t_queue_stat;

endpackage

[src/led_matrix_channel_to_pixel_mapper.sv]
// Throughput: one channel byte per cycle while the pixel queue is not full.
// One pixel word per cycle at the output while the receiver holds m_axis_tready.
// A four-deep pixel queue separates byte intake from the output register.
// Reset (synchronous, active low) clears frame counters, queue and output register
// and returns the configuration registers to their defaults.
module led_matrix_channel_to_pixel_mapper #(
    parameter int unsigned MAX_WIDTH  = 512,
    parameter int unsigned MAX_HEIGHT = 512
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [lmcp_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [lmcp_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [7:0]                          s_axis_tdata,  // data_byte
    input  logic                                s_axis_tlast,  // last_byte
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // pixel_x, pixel_y, red, green, blue, zero pad (lowest bit up)
    output logic [lmcp_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    output logic                                m_axis_tlast   // last_pixel
);
    import lmcp_pkg::*;

    t_cfg        r_cfg;
    t_pixel      front_pix, q_pix, out_pix;
    t_queue_stat q_stat;
    logic        q_push, q_pop;

    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.serpentine_mode    <= 1'b0;
            r_cfg.rgbw_enable        <= 1'b0;
            r_cfg.width              <= SIZE_W'(32);
            r_cfg.height             <= SIZE_W'(16);
            r_cfg.start_offset       <= '0;
            r_cfg.strands_per_string <= SIZE_W'(1);
            r_cfg.layout             <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_SERPENTINE: r_cfg.serpentine_mode    <= i_cfg_data[0];
                REG_RGBW:       r_cfg.rgbw_enable        <= i_cfg_data[0];
                REG_WIDTH:      r_cfg.width              <= i_cfg_data[SIZE_W-1:0];
                REG_HEIGHT:     r_cfg.height             <= i_cfg_data[SIZE_W-1:0];
                REG_START:      r_cfg.start_offset       <= i_cfg_data[SKIP_W-1:0];
                REG_STRANDS:    r_cfg.strands_per_string <= i_cfg_data[SIZE_W-1:0];
                REG_LAYOUT:     r_cfg.layout             <= i_cfg_data[LAYOUT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // byte intake and pixel placement
    lmcp_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_data   (s_axis_tdata),
        .i_last   (s_axis_tlast),
        .i_q_full (q_stat.full),
        .o_push   (q_push),
        .o_pix    (front_pix)
    );

    // pixel queue
    lmcp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (front_pix),
        .i_pop   (q_pop),
        .o_data  (q_pix),
        .o_stat  (q_stat)
    );

    // output register
    lmcp_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_stat.empty),
        .i_q_data  (q_pix),
        .o_pop     (q_pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_pix     (out_pix)
    );

    // output word packing
    assign m_axis_tdata = {OUT_PAD_W'(0), out_pix.blue, out_pix.green, out_pix.red,
                           out_pix.pixel_y, out_pix.pixel_x};
    assign m_axis_tlast = out_pix.last_pixel;

`ifndef NO_ASSERTIONS
    // the front never offers a pixel the queue cannot hold
    a_push_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_stat.full)
        else $error("pixel pushed into a full queue");

    // queue fill count tracks pushes and pops
    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (q_stat.count == $past(q_stat.count)
            + QUEUE_CW'($past(q_push)) - QUEUE_CW'($past(q_pop))))
        else $error("queue fill count out of step");

    // a waiting pixel reaches an empty output register in the next cycle
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!q_stat.empty && !m_axis_tvalid) |=> m_axis_tvalid)
        else $error("queued pixel not moved to the output");
`endif

endmodule

[src/lmcp_front.sv]
// front part: skips, groups channel bytes into pixels and places them on the matrix
module lmcp_front #(
    parameter int unsigned MAX_WIDTH  = 512,
    parameter int unsigned MAX_HEIGHT = 512
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  lmcp_pkg::t_cfg  i_cfg,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [7:0]      i_data,
    input  logic            i_last,
    input  logic            i_q_full,
    output logic            o_push,
    output lmcp_pkg::t_pixel o_pix
);
    import lmcp_pkg::*;

    localparam logic [12:0] MaxW = 13'(MAX_WIDTH);
    localparam logic [12:0] MaxH = 13'(MAX_HEIGHT);

    logic [SKIP_W-1:0] r_skip, n_skip;
    logic [1:0]        r_phase, n_phase;
    logic [7:0]        r_held [3];
    logic [7:0]        n_held [3];
    logic [SIZE_W-1:0] r_node, n_node;
    logic [SIZE_W-1:0] r_line, n_line;
    logic [SIZE_W-1:0] r_strand, n_strand;
    logic              r_full, n_full;

    logic [SIZE_W-1:0] w_eff, h_eff, len, lines;
    logic [SIZE_W-1:0] pos_a, pos_x, pos_y;
    logic [SIZE_W-1:0] node_inc, line_inc;
    logic [SIZE_W:0]   strand_inc;
    logic [2:0]        cpp, phase_inc;
    logic [7:0]        ch0, ch1, ch2, red, green, blue;
    logic              accept, active, skipping, serp, vert;
    logic              emit, out_range, wrap, lastpix;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;

    // size clamp and geometry of the current layout
    always_comb begin
        w_eff = ({3'b000, i_cfg.width} > MaxW) ? SIZE_W'(MAX_WIDTH) : i_cfg.width;
        h_eff = ({3'b000, i_cfg.height} > MaxH) ? SIZE_W'(MAX_HEIGHT) : i_cfg.height;
        serp  = i_cfg.serpentine_mode;
        vert  = serp && i_cfg.layout[LAYOUT_VERT];
        len   = vert ? h_eff : w_eff;
        lines = vert ? w_eff : h_eff;
        active   = (w_eff != '0) && (h_eff != '0) && !r_full;
        skipping = r_skip < i_cfg.start_offset;
    end

    // pixel grouping and colour selection
    always_comb begin
        cpp       = (!serp && i_cfg.rgbw_enable) ? CH_RGBW : CH_RGB;
        phase_inc = {1'b0, r_phase} + 3'd1;
        ch0 = (r_phase == 2'd0) ? i_data : r_held[0];
        ch1 = (r_phase == 2'd1) ? i_data : r_held[1];
        ch2 = (r_phase == 2'd2) ? i_data : r_held[2];
        if (r_phase == PHASE_WHITE) begin
            emit  = 1'b1;
            red   = (i_data != 8'd0) ? i_data : r_held[0];
            green = (i_data != 8'd0) ? i_data : r_held[1];
            blue  = (i_data != 8'd0) ? i_data : r_held[2];
        end else begin
            emit  = (phase_inc == cpp) || i_last;
            red   = ch0;
            green = (phase_inc >= CH_HAS_GREEN) ? ch1 : 8'd0;
            blue  = (phase_inc >= CH_RGB) ? ch2 : 8'd0;
        end
    end

    // position along the strand and matrix coordinates
    always_comb begin
        out_range  = (r_node >= len) || (r_line >= lines);
        pos_a      = (serp && r_strand[0]) ? (len - SIZE_W'(1) - r_node) : r_node;
        pos_x      = vert ? r_line : pos_a;
        pos_y      = vert ? pos_a : r_line;
        if (serp && i_cfg.layout[LAYOUT_RIGHT]) begin
            pos_x = w_eff - SIZE_W'(1) - pos_x;
        end
        if (serp && i_cfg.layout[LAYOUT_BOTTOM]) begin
            pos_y = h_eff - SIZE_W'(1) - pos_y;
        end
        node_inc   = r_node + SIZE_W'(1);
        line_inc   = r_line + SIZE_W'(1);
        strand_inc = {1'b0, r_strand} + (SIZE_W+1)'(1);
        wrap       = node_inc >= len;
        lastpix    = i_last || (wrap && (line_inc >= lines));
    end

    // next frame state
    always_comb begin
        n_skip   = r_skip;
        n_phase  = r_phase;
        n_held   = r_held;
        n_node   = r_node;
        n_line   = r_line;
        n_strand = r_strand;
        n_full   = r_full;
        o_push   = 1'b0;
        if (accept) begin
            if (active) begin
                if (skipping) begin
                    n_skip = r_skip + SKIP_W'(1);
                end else begin
                    if (r_phase != PHASE_WHITE) begin
                        n_held[r_phase] = i_data;
                        n_phase = phase_inc[1:0];
                    end
                    if (emit) begin
                        n_phase = 2'd0;
                        if (out_range) begin
                            n_full = 1'b1;
                        end else begin
                            o_push = 1'b1;
                            if (wrap) begin
                                n_node   = '0;
                                n_line   = line_inc;
                                n_strand = (strand_inc >= {1'b0, i_cfg.strands_per_string})
                                           ? '0 : strand_inc[SIZE_W-1:0];
                                if (line_inc >= lines) begin
                                    n_full = 1'b1;
                                end
                            end else begin
                                n_node = node_inc;
                            end
                        end
                    end
                end
            end
            // frame end clears everything
            if (i_last) begin
                n_skip   = '0;
                n_phase  = 2'd0;
                n_held   = '{default: 8'd0};
                n_node   = '0;
                n_line   = '0;
                n_strand = '0;
                n_full   = 1'b0;
            end
        end
    end

    // pixel word to the queue
    always_comb begin
        o_pix.pixel_x    = pos_x[COORD_W-1:0];
        o_pix.pixel_y    = pos_y[COORD_W-1:0];
        o_pix.red        = red;
        o_pix.green      = green;
        o_pix.blue       = blue;
        o_pix.last_pixel = lastpix;
    end

    // frame state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skip   <= '0;
            r_phase  <= 2'd0;
            r_held   <= '{default: 8'd0};
            r_node   <= '0;
            r_line   <= '0;
            r_strand <= '0;
            r_full   <= 1'b0;
        end else begin
            r_skip   <= n_skip;
            r_phase  <= n_phase;
            r_held   <= n_held;
            r_node   <= n_node;
            r_line   <= n_line;
            r_strand <= n_strand;
            r_full   <= n_full;
        end
    end

endmodule

[src/lmcp_queue.sv]
// short pixel queue between the front and back parts
module lmcp_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  lmcp_pkg::t_pixel      i_data,
    input  logic                  i_pop,
    output lmcp_pkg::t_pixel      o_data,
    output lmcp_pkg::t_queue_stat o_stat
);
    import lmcp_pkg::*;

    t_pixel              r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr, r_rd;
    logic [QUEUE_CW-1:0] r_count;
    logic                do_push, do_pop;

    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == QUEUE_CW'(QUEUE_DEPTH));
    assign o_stat.count = r_count;
    assign do_push = i_push && !o_stat.full;
    assign do_pop  = i_pop && !o_stat.empty;
    assign o_data  = r_mem[r_rd];

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + QUEUE_AW'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + QUEUE_AW'(1);
            end
            r_count <= r_count + QUEUE_CW'(do_push) - QUEUE_CW'(do_pop);
        end
    end

endmodule

[src/lmcp_back.sv]
// back part: output register that hands pixels to the downstream side
module lmcp_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_empty,
    input  lmcp_pkg::t_pixel i_q_data,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output lmcp_pkg::t_pixel o_pix
);
    import lmcp_pkg::*;

    logic   r_valid;
    t_pixel r_pix;

    // load when the register is empty or being taken
    assign o_pop   = !i_q_empty && (!r_valid || i_ready);
    assign o_valid = r_valid;
    assign o_pix   = r_pix;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_pix <= i_q_data;
        end
    end

endmodule

[sim/led_matrix_channel_to_pixel_mapper_test.sv]
// self-checking testbench for the led matrix channel to pixel mapper
module led_matrix_channel_to_pixel_mapper_test;
    import lmcp_pkg::*;

    localparam int unsigned MAX_COLS    = 512;
    localparam int unsigned MAX_ROWS    = 512;
    localparam int unsigned STALL_LIMIT = 1000;
    localparam int unsigned BYTE_TARGET = 1250;
    localparam int unsigned SETTLE      = 8;

    typedef enum logic [1:0] {
        ROW_BYTE,
        ROW_REG
    } t_row_kind;

    // one line of the directed table
    typedef struct packed {
        t_row_kind   kind;
        t_cfg_reg    idx;
        logic [23:0] value;
        logic [7:0]  data;
        logic        last;
        logic        typed;
        logic        hit;
        t_pixel      px;
    } t_directed_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata = '0;  // data_byte
    logic                  s_axis_tlast = 1'b0;  // last_byte
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;  // pixel_x, pixel_y, red, green, blue, zero pad
    logic                  m_axis_tlast;  // last_pixel

    // mirror of the mapper state
    t_cfg        cfg_now;
    int unsigned skip_cnt, chan_phase, node_idx, line_idx, strand_idx;
    logic [7:0]  held [3];
    bit          frame_done;

    t_pixel      pending_pixels [$];
    t_pixel      got_px, want_px;
    int unsigned errors = 0;
    int unsigned bytes_sent = 0;
    int unsigned bytes_mapped = 0;
    int unsigned pixels_seen = 0;
    int unsigned stall_cycles = 0;
    int unsigned phase_no = 0;
    bit          steady = 1'b0;

    led_matrix_channel_to_pixel_mapper i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // clock, period 12
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic void clear_frame();
        skip_cnt   = 0;
        chan_phase = 0;
        held[0]    = '0;
        held[1]    = '0;
        held[2]    = '0;
        node_idx   = 0;
        line_idx   = 0;
        strand_idx = 0;
        frame_done = 1'b0;
    endfunction

    // predicts the pixel, if any, that one channel byte produces
    function automatic bit map_byte(input logic [7:0] data, input logic last,
                                    output t_pixel px);
        int unsigned w, h, len, lines, a, c, x, y, cpp;
        bit          serp, vert, emit, last_pix;
        logic [7:0]  r, g, b;
        w = (cfg_now.width > MAX_COLS) ? MAX_COLS : cfg_now.width;
        h = (cfg_now.height > MAX_ROWS) ? MAX_ROWS : cfg_now.height;
        px = '0;
        map_byte = 1'b0;
        if (w != 0 && h != 0 && !frame_done) begin
            if (skip_cnt < cfg_now.start_offset) begin
                skip_cnt++;
            end else begin
                bytes_mapped++;
                serp = cfg_now.serpentine_mode;
                cpp  = (!serp && cfg_now.rgbw_enable) ? 4 : 3;
                emit = 1'b0;
                r = '0;
                g = '0;
                b = '0;
                // white byte: a nonzero value replaces all three colours
                if (chan_phase >= 3) begin
                    r = held[0];
                    g = held[1];
                    b = held[2];
                    if (data != 0) begin
                        r = data;
                        g = data;
                        b = data;
                    end
                    emit = 1'b1;
                end else begin
                    held[chan_phase] = data;
                    chan_phase++;
                    if (chan_phase == cpp || last) begin
                        r = held[0];
                        g = (chan_phase >= 2) ? held[1] : 8'd0;
                        b = (chan_phase >= 3) ? held[2] : 8'd0;
                        emit = 1'b1;
                    end
                end
                // place the pixel on the matrix
                if (emit) begin
                    vert  = serp && cfg_now.layout[LAYOUT_VERT];
                    len   = vert ? h : w;
                    lines = vert ? w : h;
                    chan_phase = 0;
                    if (node_idx >= len || line_idx >= lines) begin
                        frame_done = 1'b1;
                    end else begin
                        a = node_idx;
                        c = line_idx;
                        last_pix = last;
                        if (serp && strand_idx[0]) a = len - 1 - node_idx;
                        x = vert ? c : a;
                        y = vert ? a : c;
                        if (serp && cfg_now.layout[LAYOUT_RIGHT]) x = w - 1 - x;
                        if (serp && cfg_now.layout[LAYOUT_BOTTOM]) y = h - 1 - y;
                        node_idx++;
                        if (node_idx >= len) begin
                            node_idx = 0;
                            line_idx++;
                            strand_idx++;
                            if (strand_idx >= cfg_now.strands_per_string) strand_idx = 0;
                            if (line_idx >= lines) begin
                                frame_done = 1'b1;
                                last_pix = 1'b1;
                            end
                        end
                        px.pixel_x    = x[COORD_W-1:0];
                        px.pixel_y    = y[COORD_W-1:0];
                        px.red        = r;
                        px.green      = g;
                        px.blue       = b;
                        px.last_pixel = last_pix;
                        map_byte = 1'b1;
                    end
                end
            end
        end
        if (last) clear_frame();
    endfunction

    // table row builders
    function automatic t_directed_row byte_row(input logic [7:0] data, input logic last);
        t_directed_row row;
        row       = '0;
        row.kind  = ROW_BYTE;
        row.data  = data;
        row.last  = last;
        return row;
    endfunction

    function automatic t_directed_row quiet_row(input logic [7:0] data, input logic last);
        t_directed_row row;
        row       = byte_row(data, last);
        row.typed = 1'b1;
        return row;
    endfunction

    function automatic t_directed_row pixel_row(input logic [7:0] data, input logic last,
                                                input int unsigned x, input int unsigned y,
                                                input logic [7:0] r, input logic [7:0] g,
                                                input logic [7:0] b, input logic lp);
        t_directed_row row;
        row               = quiet_row(data, last);
        row.hit           = 1'b1;
        row.px.pixel_x    = x[COORD_W-1:0];
        row.px.pixel_y    = y[COORD_W-1:0];
        row.px.red        = r;
        row.px.green      = g;
        row.px.blue       = b;
        row.px.last_pixel = lp;
        return row;
    endfunction

    function automatic t_directed_row reg_row(input t_cfg_reg idx, input int unsigned value);
        t_directed_row row;
        row       = '0;
        row.kind  = ROW_REG;
        row.idx   = idx;
        row.value = value[23:0];
        return row;
    endfunction

    // random sizes: mostly tiny, with zero, full size and oversize now and then
    function automatic logic [9:0] pick_size();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 7) return 10'd0;
        if (roll < 15) return 10'd512;
        if (roll < 20) return 10'($urandom_range(1023, 513));
        if (roll < 30) return 10'($urandom_range(512, 1));
        return 10'($urandom_range(5, 1));
    endfunction

    task automatic write_reg(input t_cfg_reg idx, input logic [23:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            REG_SERPENTINE: cfg_now.serpentine_mode    = value[0];
            REG_RGBW:       cfg_now.rgbw_enable        = value[0];
            REG_WIDTH:      cfg_now.width              = value[SIZE_W-1:0];
            REG_HEIGHT:     cfg_now.height             = value[SIZE_W-1:0];
            REG_START:      cfg_now.start_offset       = value[SKIP_W-1:0];
            REG_STRANDS:    cfg_now.strands_per_string = value[SIZE_W-1:0];
            REG_LAYOUT:     cfg_now.layout             = value[LAYOUT_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // one channel byte, with random gaps before it outside steady phases
    task automatic send_byte(input logic [7:0] data, input logic last,
                             output bit hit, output t_pixel px);
        @(negedge i_clk);
        while (!steady && $urandom_range(99) < 14) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        hit = map_byte(data, last, px);
        bytes_sent++;
    endtask

    // hold the sender until every pixel is out and the pipeline is empty
    task automatic drain_pixels();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // receiver back-pressure
    always @(negedge i_clk) begin
        m_axis_tready <= steady || ($urandom_range(99) >= 14);
    end

    // pixel word checker
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_px.pixel_x    = m_axis_tdata[8:0];
            got_px.pixel_y    = m_axis_tdata[17:9];
            got_px.red        = m_axis_tdata[25:18];
            got_px.green      = m_axis_tdata[33:26];
            got_px.blue       = m_axis_tdata[41:34];
            got_px.last_pixel = m_axis_tlast;
            pixels_seen++;
            if (pending_pixels.size() == 0) begin
                $display("%0t: pixel word with none expected, actual x=%0d y=%0d rgb=%h",
                         $time, got_px.pixel_x, got_px.pixel_y, m_axis_tdata[41:18]);
                errors++;
            end else begin
                want_px = pending_pixels.pop_front();
                check_field("pixel_x", want_px.pixel_x, got_px.pixel_x);
                check_field("pixel_y", want_px.pixel_y, got_px.pixel_y);
                check_field("red", want_px.red, got_px.red);
                check_field("green", want_px.green, got_px.green);
                check_field("blue", want_px.blue, got_px.blue);
                check_field("last_pixel", want_px.last_pixel, got_px.last_pixel);
            end
        end
    end

    // watchdog on cycles without any word moving
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("Some tests failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        t_directed_row plan [$];
        bit            hit;
        bit            busy;
        bit            leave_open;
        t_pixel        px;
        int unsigned   frames, len, need, wc, hc, cpp, roll;

        // defaults after reset
        cfg_now.serpentine_mode    = 1'b0;
        cfg_now.rgbw_enable        = 1'b0;
        cfg_now.width              = 10'd32;
        cfg_now.height             = 10'd16;
        cfg_now.start_offset       = '0;
        cfg_now.strands_per_string = 10'd1;
        cfg_now.layout             = '0;
        clear_frame();
        busy = 1'b0;

        // reset defaults: full pixel, then one-byte partial pixel at frame end
        plan.push_back(quiet_row(8'hFF, 1'b0));
        plan.push_back(quiet_row(8'h00, 1'b0));
        plan.push_back(pixel_row(8'h80, 1'b0, 0, 0, 8'hFF, 8'h00, 8'h80, 1'b0));
        plan.push_back(pixel_row(8'h12, 1'b1, 1, 0, 8'h12, 8'h00, 8'h00, 1'b1));
        // rgbw white override, then white taken after rgbw is switched off mid-pixel
        plan.push_back(reg_row(REG_RGBW, 1));
        plan.push_back(byte_row(8'h11, 1'b0));
        plan.push_back(byte_row(8'h22, 1'b0));
        plan.push_back(byte_row(8'h33, 1'b0));
        plan.push_back(pixel_row(8'h77, 1'b0, 0, 0, 8'h77, 8'h77, 8'h77, 1'b0));
        plan.push_back(byte_row(8'h05, 1'b0));
        plan.push_back(byte_row(8'h06, 1'b0));
        plan.push_back(byte_row(8'h07, 1'b0));
        plan.push_back(reg_row(REG_RGBW, 0));
        plan.push_back(pixel_row(8'h44, 1'b1, 1, 0, 8'h44, 8'h44, 8'h44, 1'b1));
        // one-pixel matrix: frame fills, later bytes dropped
        plan.push_back(reg_row(REG_WIDTH, 1));
        plan.push_back(reg_row(REG_HEIGHT, 1));
        plan.push_back(byte_row(8'h09, 1'b0));
        plan.push_back(byte_row(8'h08, 1'b0));
        plan.push_back(pixel_row(8'h07, 1'b0, 0, 0, 8'h09, 8'h08, 8'h07, 1'b1));
        plan.push_back(quiet_row(8'hAA, 1'b1));
        // zero width
        plan.push_back(reg_row(REG_WIDTH, 0));
        plan.push_back(quiet_row(8'h55, 1'b1));
        // frame that ends while still skipping
        plan.push_back(reg_row(REG_WIDTH, 2));
        plan.push_back(reg_row(REG_HEIGHT, 2));
        plan.push_back(reg_row(REG_START, 2));
        plan.push_back(quiet_row(8'h01, 1'b0));
        plan.push_back(quiet_row(8'h02, 1'b1));
        // serpentine from the bottom right corner
        plan.push_back(reg_row(REG_START, 0));
        plan.push_back(reg_row(REG_SERPENTINE, 1));
        plan.push_back(reg_row(REG_LAYOUT, 3));
        plan.push_back(reg_row(REG_STRANDS, 2));
        plan.push_back(byte_row(8'hA1, 1'b0));
        plan.push_back(byte_row(8'hA2, 1'b0));
        plan.push_back(pixel_row(8'hA3, 1'b0, 1, 1, 8'hA1, 8'hA2, 8'hA3, 1'b0));
        // shrink mid-frame so the position falls outside the matrix
        plan.push_back(reg_row(REG_WIDTH, 1));
        plan.push_back(byte_row(8'hB1, 1'b0));
        plan.push_back(byte_row(8'hB2, 1'b0));
        plan.push_back(quiet_row(8'hB3, 1'b1));

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        foreach (plan[i]) begin
            if (plan[i].kind == ROW_REG) begin
                if (busy) drain_pixels();
                busy = 1'b0;
                write_reg(plan[i].idx, plan[i].value);
            end else begin
                send_byte(plan[i].data, plan[i].last, hit, px);
                if (plan[i].typed) begin
                    hit = plan[i].hit;
                    px  = plan[i].px;
                end
                if (hit) pending_pixels.push_back(px);
                busy = 1'b1;
            end
        end

        // random phases: new settings, then a few frames, some left open
        while (bytes_sent < BYTE_TARGET) begin
            drain_pixels();
            steady = (phase_no >= 8 && phase_no < 16);
            if ($urandom_range(1)) write_reg(REG_SERPENTINE, 24'($urandom_range(1)));
            if ($urandom_range(1)) write_reg(REG_RGBW, 24'($urandom_range(1)));
            if ($urandom_range(1)) write_reg(REG_WIDTH, 24'(pick_size()));
            if ($urandom_range(1)) write_reg(REG_HEIGHT, 24'(pick_size()));
            if ($urandom_range(1)) write_reg(REG_LAYOUT, 24'($urandom_range(7)));
            if ($urandom_range(2) == 0) begin
                roll = $urandom_range(99);
                if (roll < 10) write_reg(REG_STRANDS, 24'd0);
                else if (roll < 15) write_reg(REG_STRANDS, 24'd512);
                else if (roll < 20) write_reg(REG_STRANDS, 24'd1023);
                else write_reg(REG_STRANDS, 24'($urandom_range(4, 1)));
            end
            if ($urandom_range(2) == 0) begin
                roll = $urandom_range(99);
                if (roll < 50) write_reg(REG_START, 24'd0);
                else if (roll < 85) write_reg(REG_START, 24'($urandom_range(7, 1)));
                else if (roll < 95) write_reg(REG_START, 24'($urandom_range(60, 8)));
                else write_reg(REG_START, 24'hFFFFFF);
            end

            frames = $urandom_range(4, 1);
            for (int f = 0; f < frames; f++) begin
                wc   = (cfg_now.width > MAX_COLS) ? MAX_COLS : cfg_now.width;
                hc   = (cfg_now.height > MAX_ROWS) ? MAX_ROWS : cfg_now.height;
                cpp  = (!cfg_now.serpentine_mode && cfg_now.rgbw_enable) ? 4 : 3;
                need = cfg_now.start_offset + wc * hc * cpp;
                // for small matrices mostly frames sized around a full matrix, otherwise short ones
                if (need <= 150 && $urandom_range(3) != 0)
                    len = ((need > 2) ? need - 2 : 1) + $urandom_range(4);
                else
                    len = $urandom_range(40, 1);
                leave_open = (f == frames - 1) && ($urandom_range(9) < 3);
                for (int k = 0; k < len; k++) begin
                    send_byte(8'($urandom_range(255)), (k == len - 1) && !leave_open, hit, px);
                    if (hit) pending_pixels.push_back(px);
                end
            end
            phase_no++;
        end

        steady = 1'b0;
        drain_pixels();

        $display("sent %0d channel bytes (%0d grouped into pixels), checked %0d pixel words",
                 bytes_sent, bytes_mapped, pixels_seen);
        $display("covered %0d random setting phases over raster, rgbw and serpentine layouts",
                 phase_no);
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
